// ===== rtl/drfm_pkg.sv =====
`default_nettype none

package drfm_pkg;

   localparam int unsigned PAGE_SHIFT = 12;
   localparam logic [31:0] PAGE_LOW_MASK = 32'h0000_0FFF;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_FAULT = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_ADDED      = 3'd0,
      STAT_FULL       = 3'd1,
      STAT_CLEARED    = 3'd2,
      STAT_RESOLVED   = 3'd3,
      STAT_PROTECT    = 3'd4,
      STAT_UNPROMISED = 3'd5,
      STAT_NOFRAME    = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [19:0] space_id;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [11:0] map_attrs;
      logic [31:0] fault_addr;
      logic        page_present;
      logic        frame_available;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        map_valid;
      logic [19:0] map_space;
      logic [19:0] map_page;
      logic [11:0] map_flags;
      logic [31:0] served_count;
   } rsp_type;

   typedef struct packed {
      logic [19:0] space;
      logic [19:0] first_page;
      logic [19:0] limit_page;
      logic [11:0] flags;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } store_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/demand_region_fault_matcher.sv =====
// add, clear, protection and unknown commands: result strobe in the cycle after the beat
// fault lookup: reads one region slot per cycle from the table memory, slot 0 first;
//   result strobe after the first matching slot, or after the last slot when none match
// busy is high only during a fault lookup; a new beat may follow any result at once
// synchronous reset empties the table and zeroes the served counter, no clearing pass
// results are never held off by the receiver
`default_nettype none

module demand_region_fault_matcher #(
   parameter int REGION_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire drfm_pkg::req_type req_item,
   output      logic              rsp_strobe,
   output      drfm_pkg::rsp_type rsp_item
);
   import drfm_pkg::*;

   localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

   store_ctl_type           ctl;
   logic [SLOT_W-1:0]       rd_addr;
   logic [SLOT_W-1:0]       wr_addr;
   entry_type               wr_data;
   entry_type               rd_data;
   logic [REGION_SLOTS-1:0] valid_vec;

   drfm_ctrl #(
      .REGION_SLOTS(REGION_SLOTS),
      .SLOT_W(SLOT_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item),
      .ctl(ctl),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data),
      .valid_vec(valid_vec)
   );

   drfm_store #(
      .REGION_SLOTS(REGION_SLOTS),
      .SLOT_W(SLOT_W)
   ) u_store (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_data(rd_data),
      .valid_vec(valid_vec)
   );

endmodule

`default_nettype wire

// ===== rtl/drfm_store.sv =====
`default_nettype none

module drfm_store #(
   parameter int REGION_SLOTS = 16,
   parameter int SLOT_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire drfm_pkg::store_ctl_type    ctl,
   input  wire logic [SLOT_W-1:0]          rd_addr,
   input  wire logic [SLOT_W-1:0]          wr_addr,
   input  wire drfm_pkg::entry_type        wr_data,
   output      drfm_pkg::entry_type        rd_data,
   output      logic [REGION_SLOTS-1:0]    valid_vec
);
   import drfm_pkg::*;

   entry_type               mem [REGION_SLOTS];
   entry_type               rd_data_ff;
   logic [REGION_SLOTS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data   = rd_data_ff;
   assign valid_vec = valid_ff;

endmodule

`default_nettype wire

// ===== rtl/drfm_ctrl.sv =====
`default_nettype none

module drfm_ctrl #(
   parameter int REGION_SLOTS = 16,
   parameter int SLOT_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire drfm_pkg::req_type          req_item,
   output      logic                       rsp_strobe,
   output      drfm_pkg::rsp_type          rsp_item,
   output      drfm_pkg::store_ctl_type    ctl,
   output      logic [SLOT_W-1:0]          rd_addr,
   output      logic [SLOT_W-1:0]          wr_addr,
   output      drfm_pkg::entry_type        wr_data,
   input  wire drfm_pkg::entry_type        rd_data,
   input  wire logic [REGION_SLOTS-1:0]    valid_vec
);
   import drfm_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(REGION_SLOTS - 1);

   typedef enum logic {IDLE, SCAN} fsm_type;

   fsm_type           state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [19:0]       space_ff, space_in;
   logic [19:0]       page_ff, page_in;
   logic              frame_ff, frame_in;
   logic [31:0]       cnt_ff, cnt_in;
   logic              strobe_ff, strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              free_found;
   logic [SLOT_W-1:0] free_idx;
   logic [31:0]       end_sum;
   logic [SLOT_W-1:0] idx_next;
   logic              hit;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign end_sum  = req_item.range_end + PAGE_LOW_MASK;
   assign idx_next = idx_ff + 1'b1;
   assign hit      = valid_vec[idx_ff] && (rd_data.space == space_ff)
                     && (page_ff >= rd_data.first_page) && (page_ff < rd_data.limit_page);

   assign wr_addr = free_idx;
   assign wr_data = '{space:      req_item.space_id,
                      first_page: req_item.range_start[31:PAGE_SHIFT],
                      limit_page: end_sum[31:PAGE_SHIFT],
                      flags:      req_item.map_attrs};

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      space_in  = space_ff;
      page_in   = page_ff;
      frame_in  = frame_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      ctl       = '0;
      rd_addr   = idx_next;
      case (state_ff)
         IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               rsp_in    = '0;
               case (req_item.cmd)
                  CMD_ADD: begin
                     ctl.wr_en     = free_found;
                     rsp_in.status = free_found ? STAT_ADDED : STAT_FULL;
                  end
                  CMD_CLEAR: begin
                     ctl.clear     = 1'b1;
                     cnt_in        = '0;
                     rsp_in.status = STAT_CLEARED;
                  end
                  CMD_FAULT: begin
                     if (req_item.page_present) begin
                        rsp_in.status = STAT_PROTECT;
                     end else begin
                        strobe_in = 1'b0;
                        rsp_in    = rsp_ff;
                        ctl.rd_en = 1'b1;
                        rd_addr   = '0;
                        idx_in    = '0;
                        space_in  = req_item.space_id;
                        page_in   = req_item.fault_addr[31:PAGE_SHIFT];
                        frame_in  = req_item.frame_available;
                        state_in  = SCAN;
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_UNPROMISED;
                  end
               endcase
               rsp_in.served_count = cnt_in;
            end
         end
         SCAN: begin
            ctl.rd_en = 1'b1;
            if (hit || idx_ff == LAST_SLOT) begin
               strobe_in = 1'b1;
               state_in  = IDLE;
               rsp_in    = '0;
               if (hit && frame_ff) begin
                  cnt_in           = cnt_ff + 32'd1;
                  rsp_in.status    = STAT_RESOLVED;
                  rsp_in.map_valid = 1'b1;
                  rsp_in.map_space = rd_data.space;
                  rsp_in.map_page  = page_ff;
                  rsp_in.map_flags = rd_data.flags;
               end else if (hit) begin
                  rsp_in.status = STAT_NOFRAME;
               end else begin
                  rsp_in.status = STAT_UNPROMISED;
               end
               rsp_in.served_count = cnt_in;
            end else begin
               idx_in = idx_next;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      space_ff <= space_in;
      page_ff  <= page_in;
      frame_ff <= frame_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/drfm_checker.sv =====
`default_nettype none

module drfm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire drfm_pkg::req_type req_item,
   input wire logic              rsp_strobe,
   input wire drfm_pkg::rsp_type rsp_item
);
   import drfm_pkg::*;

   // map fields only carry data on a resolved fault
   a_map_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != STAT_RESOLVED |->
         !rsp_item.map_valid && rsp_item.map_space == '0
         && rsp_item.map_page == '0 && rsp_item.map_flags == '0)
      else $error("map fields set on non-resolved result");

   a_resolved_map: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status == STAT_RESOLVED |-> rsp_item.map_valid)
      else $error("resolved result without map request");

   // clear answers on the next cycle with a zero counter
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_CLEAR |=>
         rsp_strobe && rsp_item.status == STAT_CLEARED && rsp_item.served_count == '0)
      else $error("clear beat not answered next cycle");

   // protection fault is rejected on the next cycle without a lookup
   a_protect_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.cmd == CMD_FAULT && req_item.page_present |=>
         rsp_strobe && rsp_item.status == STAT_PROTECT && !busy)
      else $error("protection fault not rejected next cycle");

endmodule

bind demand_region_fault_matcher drfm_checker u_drfm_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_item(req_item),
   .rsp_strobe(rsp_strobe),
   .rsp_item(rsp_item)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import drfm_pkg::*;

   localparam int SLOTS = 16;
   localparam int RANDOM_ITEMS = 1230;
   localparam int CYCLE_LIMIT = 300000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // shadow of the region table and served counter
   logic        region_live [SLOTS];
   logic [19:0] region_space [SLOTS];
   logic [19:0] region_first [SLOTS];
   logic [19:0] region_limit [SLOTS];
   logic [11:0] region_flags [SLOTS];
   logic [31:0] served_total;

   rsp_type     pending_outcomes[$];
   int          mismatch_count;
   int          cycle_count;
   int          gapless_run;
   logic [19:0] space_pool [4] = '{20'h00000, 20'hFFFFF, 20'h12345, 20'hABCDE};

   demand_region_fault_matcher #(
      .REGION_SLOTS(SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      served_total = '0;
      mismatch_count = 0;
      cycle_count = 0;
      gapless_run = 0;
      for (int i = 0; i < SLOTS; i++) begin
         region_live[i] = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic rsp_type model_command(req_type item);
      rsp_type     outcome;
      logic [31:0] end_rounded;
      logic [19:0] page;
      bit          done;
      outcome = '0;
      outcome.status = STAT_UNPROMISED;
      done = 1'b0;
      case (item.cmd)
         CMD_ADD: begin
            outcome.status = STAT_FULL;
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && !region_live[i]) begin
                  end_rounded = (item.range_end + 32'h0000_0FFF) & 32'hFFFF_F000;
                  region_live[i] = 1'b1;
                  region_space[i] = item.space_id;
                  region_first[i] = item.range_start[31:12];
                  region_limit[i] = end_rounded[31:12];
                  region_flags[i] = item.map_attrs;
                  outcome.status = STAT_ADDED;
                  done = 1'b1;
               end
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               region_live[i] = 1'b0;
            end
            served_total = '0;
            outcome.status = STAT_CLEARED;
         end
         CMD_FAULT: begin
            page = item.fault_addr[31:12];
            if (item.page_present) begin
               outcome.status = STAT_PROTECT;
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!done && region_live[i] && region_space[i] == item.space_id &&
                      page >= region_first[i] && page < region_limit[i]) begin
                     done = 1'b1;
                     if (!item.frame_available) begin
                        outcome.status = STAT_NOFRAME;
                     end else begin
                        outcome.status = STAT_RESOLVED;
                        outcome.map_valid = 1'b1;
                        outcome.map_space = region_space[i];
                        outcome.map_page = page;
                        outcome.map_flags = region_flags[i];
                        served_total = served_total + 32'd1;
                     end
                  end
               end
            end
         end
         default: begin
            outcome.status = STAT_UNPROMISED;
         end
      endcase
      outcome.served_count = served_total;
      return outcome;
   endfunction

   function automatic req_type scrambled_request(cmd_type op);
      req_type item;
      item.cmd = op;
      item.space_id = 20'($urandom);
      item.range_start = $urandom;
      item.range_end = $urandom;
      item.map_attrs = 12'($urandom);
      item.fault_addr = $urandom;
      item.page_present = 1'($urandom);
      item.frame_available = 1'($urandom);
      return item;
   endfunction

   // start stays high across back-to-back beats
   task automatic send_beat(req_type item);
      int gap;
      if (gapless_run > 0) begin
         gap = 0;
         gapless_run--;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 39) == 0) begin
            gapless_run = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      do begin
         @(posedge clock);
      end while (busy !== 1'b0);
      pending_outcomes.push_back(model_command(item));
   endtask

   task automatic send_add(logic [19:0] space, logic [31:0] lo, logic [31:0] hi,
                           logic [11:0] attrs);
      req_type item;
      item = scrambled_request(CMD_ADD);
      item.space_id = space;
      item.range_start = lo;
      item.range_end = hi;
      item.map_attrs = attrs;
      send_beat(item);
   endtask

   task automatic send_fault(logic [19:0] space, logic [31:0] addr, logic present,
                             logic frame);
      req_type item;
      item = scrambled_request(CMD_FAULT);
      item.space_id = space;
      item.fault_addr = addr;
      item.page_present = present;
      item.frame_available = frame;
      send_beat(item);
   endtask

   task automatic flag_mismatch(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: want status %0d map %0b space %h page %h flags %h count %h",
                  what, want.status, want.map_valid, want.map_space, want.map_page,
                  want.map_flags, want.served_count);
         $display("   got status %0d map %0b space %h page %h flags %h count %h",
                  got.status, got.map_valid, got.map_space, got.map_page,
                  got.map_flags, got.served_count);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("unexpected result", '0, rsp_item);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.map_valid !== want.map_valid ||
                rsp_item.map_space !== want.map_space ||
                rsp_item.map_page !== want.map_page ||
                rsp_item.map_flags !== want.map_flags ||
                rsp_item.served_count !== want.served_count) begin
               flag_mismatch("result mismatch", want, rsp_item);
            end
         end
      end
   end

   // every slot written once, rounding and wrap cases, then one add too many
   task automatic test_fill_and_full();
      send_add(20'h00000, 32'h0000_0000, 32'h0000_3000, 12'h000);
      send_add(20'hFFFFF, 32'hFFFF_E123, 32'hFFFF_F000, 12'hFFF);
      send_add(20'h12345, 32'h1000_0FFF, 32'h1000_5001, 12'hA5A);
      send_add(20'h12345, 32'h1000_2000, 32'h2000_0000, 12'h5A5);
      send_add(20'hABCDE, 32'h4000_0000, 32'hFFFF_FFFF, 12'h001);
      send_add(20'hABCDE, 32'h5000_0000, 32'h4000_0000, 12'h800);
      send_add(20'hABCDE, 32'h6000_0000, 32'h6000_0000, 12'h0F0);
      send_add(20'h55555, 32'hFFFF_F000, 32'hFFFF_F001, 12'h777);
      for (int i = 8; i < SLOTS - 1; i++) begin
         send_add(20'(20'h2AAA0 + i), 32'(i) << 24, (32'(i) << 24) + 32'h8000, 12'(i));
      end
      send_add(20'h0F0F0, 32'h7000_0000, 32'h7001_0000, 12'h3C3);
      send_add(20'h99999, 32'h8000_0000, 32'h8000_1000, 12'h111);
   endtask

   task automatic test_fault_outcomes();
      req_type item;
      send_fault(20'h12345, 32'h1000_3ABC, 1'b0, 1'b1);
      send_fault(20'hFFFFF, 32'hFFFF_EFFF, 1'b0, 1'b1);
      send_fault(20'h0F0F0, 32'h7000_FFFF, 1'b0, 1'b1);
      send_fault(20'hABCDE, 32'h6000_0000, 1'b0, 1'b1);
      send_fault(20'h00000, 32'h0000_1000, 1'b0, 1'b0);
      send_fault(20'h12345, 32'h1000_3000, 1'b1, 1'b1);
      item = scrambled_request(CMD_NONE);
      send_beat(item);
   endtask

   task automatic test_clear();
      send_beat(scrambled_request(CMD_CLEAR));
      send_fault(20'h12345, 32'h1000_3ABC, 1'b0, 1'b1);
   endtask

   task automatic test_random_traffic();
      req_type     item;
      int          roll;
      int          slot;
      int          live[$];
      logic [19:0] page;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            item = scrambled_request(CMD_CLEAR);
         end else if (roll < 7) begin
            item = scrambled_request(CMD_NONE);
         end else if (roll < 35) begin
            item = scrambled_request(CMD_ADD);
            if ($urandom_range(0, 4) != 0) begin
               item.space_id = space_pool[$urandom_range(0, 3)];
            end
            roll = $urandom_range(0, 9);
            if (roll < 7) begin
               item.range_end = item.range_start + $urandom_range(0, 32'h20000);
            end else if (roll == 7) begin
               item.range_end = item.range_start;
            end else if (roll == 8) begin
               item.range_end = 32'hFFFF_F000 + $urandom_range(0, 32'hFFF);
            end
         end else begin
            item = scrambled_request(CMD_FAULT);
            item.page_present = ($urandom_range(0, 9) == 0);
            item.frame_available = ($urandom_range(0, 4) != 0);
            live.delete();
            for (int i = 0; i < SLOTS; i++) begin
               if (region_live[i]) begin
                  live.push_back(i);
               end
            end
            roll = $urandom_range(0, 19);
            if (live.size() > 0 && roll < 17) begin
               slot = live[$urandom_range(0, live.size() - 1)];
               if ($urandom_range(0, 6) != 0) begin
                  item.space_id = region_space[slot];
               end else begin
                  item.space_id = space_pool[$urandom_range(0, 3)];
               end
               if (roll < 13 && region_first[slot] < region_limit[slot]) begin
                  page = 20'(region_first[slot] +
                         $urandom_range(0, region_limit[slot] - region_first[slot] - 1));
               end else if (roll < 15) begin
                  page = region_limit[slot];
               end else begin
                  page = region_first[slot] - 20'd1;
               end
               item.fault_addr[31:12] = page;
            end
         end
         send_beat(item);
      end
   endtask

   initial begin
      start <= 1'b0;
      reset <= 1'b1;
      req_item <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_fill_and_full();
      test_fault_outcomes();
      test_clear();
      test_random_traffic();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SLOTS + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
